// File: rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// File: rtl/core/ks_pkg.sv
`default_nettype none

package ks_pkg;

   localparam int WORD_BITS_DEFAULT = 64;
   localparam int FIELD_BITS        = 64;
   localparam int SYMBOL_BITS       = 2;

   localparam logic signed [SYMBOL_BITS-1:0] SYM_ZERO  = 2'sb00;
   localparam logic signed [SYMBOL_BITS-1:0] SYM_ONE   = 2'sb01;
   localparam logic signed [SYMBOL_BITS-1:0] SYM_MINUS = 2'sb11;

   // symbol of 2 over n, indexed by n mod 8
   localparam logic signed [SYMBOL_BITS-1:0] SIGN_TAB [8] = '{
      2'sb00, 2'sb01, 2'sb00, 2'sb11, 2'sb00, 2'sb11, 2'sb00, 2'sb01
   };

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SETUP,
      OP_STRIP,
      OP_DIVIDE,
      OP_ADJUST,
      OP_REDUCE,
      OP_EMIT
   } ks_op_type;

   typedef struct packed {
      ks_op_type op;
   } ks_cmd_type;

   typedef struct packed {
      logic b_zero;
      logic both_even;
      logic ub_last;
      logic ua_zero;
   } ks_stat_type;

   function automatic logic tab_neg(input logic [2:0] idx);
      return SIGN_TAB[idx] == SYM_MINUS;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/ks_dpath.sv
`default_nettype none

module ks_dpath #(
   parameter int WORD_BITS = 64
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire ks_pkg::ks_cmd_type                       cmd,
   output ks_pkg::ks_stat_type                           stat,
   input  wire logic [WORD_BITS-1:0]                     upper_in,
   input  wire logic [WORD_BITS-1:0]                     lower_in,
   output logic signed [ks_pkg::SYMBOL_BITS-1:0]         symbol_out
);
   import ks_pkg::*;
   `include "assert_macros.svh"

   localparam int W = WORD_BITS;

   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [W-1:0] ub_ff, ub_in, ua_ff, ua_in;
   logic [W-1:0] rem_ff, rem_in, q_ff, q_in;
   logic         k_neg_ff, k_neg_in;
   logic signed [SYMBOL_BITS-1:0] sym_ff, sym_in;

   logic         a_neg, b_neg;
   logic [W-1:0] a_mag, b_mag;
   logic [W-1:0] trial, trial_diff;
   logic         trial_ge;
   logic         ub_gt;
   logic [W-1:0] sub_x, sub_y, sub_d;
   logic signed [SYMBOL_BITS-1:0] sym_now;

   assign a_neg = a_ff[W-1];
   assign b_neg = b_ff[W-1];
   assign a_mag = a_neg ? (W'(0) - a_ff) : a_ff;
   assign b_mag = b_neg ? (W'(0) - b_ff) : b_ff;

   // one restoring step of the division of |a| by ub
   assign trial      = {rem_ff[W-2:0], q_ff[W-1]};
   assign trial_ge   = trial >= ub_ff;
   assign trial_diff = trial - ub_ff;

   // shared subtractor for the reduce loop
   assign ub_gt = ub_ff > ua_ff;
   assign sub_x = ub_gt ? ub_ff : ua_ff;
   assign sub_y = ub_gt ? ua_ff : ub_ff;
   assign sub_d = sub_x - sub_y;

   always_comb begin
      if (b_ff == '0) begin
         sym_now = (a_ff == W'(1) || (&a_ff)) ? SYM_ONE : SYM_ZERO;
      end else if (!a_ff[0] && !b_ff[0]) begin
         sym_now = SYM_ZERO;
      end else if (ub_ff > W'(1)) begin
         sym_now = SYM_ZERO;
      end else begin
         sym_now = k_neg_ff ? SYM_MINUS : SYM_ONE;
      end
   end

   always_comb begin
      a_in     = a_ff;
      b_in     = b_ff;
      ub_in    = ub_ff;
      ua_in    = ua_ff;
      rem_in   = rem_ff;
      q_in     = q_ff;
      k_neg_in = k_neg_ff;
      sym_in   = sym_ff;
      unique case (cmd.op)
         OP_NONE: begin
         end
         OP_LOAD: begin
            a_in = upper_in;
            b_in = lower_in;
         end
         OP_SETUP: begin
            ub_in    = b_mag;
            q_in     = a_mag;
            rem_in   = '0;
            k_neg_in = a_neg & b_neg;
         end
         OP_STRIP: begin
            if (ub_ff[1:0] == 2'b00) begin
               ub_in = ub_ff >> 2;
            end else if (!ub_ff[0]) begin
               ub_in    = ub_ff >> 1;
               k_neg_in = k_neg_ff ^ tab_neg(a_ff[2:0]);
            end
         end
         OP_DIVIDE: begin
            rem_in = trial_ge ? trial_diff : trial;
            q_in   = q_ff << 1;
         end
         OP_ADJUST: begin
            ua_in = (a_neg && rem_ff != '0) ? (ub_ff - rem_ff) : rem_ff;
         end
         OP_REDUCE: begin
            if (ua_ff[1:0] == 2'b00) begin
               ua_in = ua_ff >> 2;
            end else if (!ua_ff[0]) begin
               ua_in    = ua_ff >> 1;
               k_neg_in = k_neg_ff ^ tab_neg(ub_ff[2:0]);
            end else if (ub_gt) begin
               if (ua_ff[1:0] == 2'b11 && ub_ff[1:0] == 2'b11) begin
                  k_neg_in = ~k_neg_ff;
               end
               ub_in = ua_ff;
               ua_in = sub_d;
            end else begin
               ua_in = sub_d;
            end
         end
         OP_EMIT: begin
            sym_in = sym_now;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      ub_ff    <= ub_in;
      ua_ff    <= ua_in;
      rem_ff   <= rem_in;
      q_ff     <= q_in;
      k_neg_ff <= k_neg_in;
      sym_ff   <= sym_in;
   end

   assign stat.b_zero    = (b_ff == '0);
   assign stat.both_even = !a_ff[0] && !b_ff[0];
   assign stat.ub_last   = (ub_ff[1:0] != 2'b00);
   assign stat.ua_zero   = (ua_ff == '0);
   assign symbol_out     = sym_ff;

   `ASSERT_CLK(a_ub_odd_in_reduce, clock, reset, (cmd.op == OP_REDUCE) |-> ub_ff[0], "ub even in reduce loop")
   `ASSERT_CLK(a_rem_below_ub, clock, reset, (cmd.op == OP_ADJUST) |-> (rem_ff < ub_ff), "remainder not below divisor")
   `ASSERT_CLK(a_emit_legal, clock, reset, (cmd.op == OP_EMIT) |=> (sym_ff != 2'sb10), "illegal symbol code")

endmodule

`default_nettype wire

// File: rtl/core/ks_ctrl.sv
`default_nettype none

module ks_ctrl #(
   parameter int WORD_BITS = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   input  wire ks_pkg::ks_stat_type stat,
   output ks_pkg::ks_cmd_type       cmd
);
   import ks_pkg::*;
   `include "assert_macros.svh"

   localparam int CW = $clog2(WORD_BITS);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_STRIP,
      S_DIVIDE,
      S_ADJUST,
      S_REDUCE,
      S_FINISH
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            if (stat.b_zero || stat.both_even) begin
               state_in = S_FINISH;
            end else begin
               cmd.op   = OP_SETUP;
               state_in = S_STRIP;
            end
         end
         S_STRIP: begin
            cmd.op = OP_STRIP;
            if (stat.ub_last) begin
               cnt_in   = '0;
               state_in = S_DIVIDE;
            end
         end
         S_DIVIDE: begin
            cmd.op = OP_DIVIDE;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WORD_BITS - 1)) begin
               state_in = S_ADJUST;
            end
         end
         S_ADJUST: begin
            cmd.op   = OP_ADJUST;
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            if (stat.ua_zero) begin
               state_in = S_FINISH;
            end else begin
               cmd.op = OP_REDUCE;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `ASSERT_CLK(a_busy_after_accept, clock, reset, (req_valid && req_ready) |=> !req_ready, "ready after accept")
   `ASSERT_CLK(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(cmd.op == OP_EMIT), "response without emit")
   `ASSERT_CLK(a_cnt_range, clock, reset, (state_ff == S_DIVIDE) |-> (cnt_ff <= CW'(WORD_BITS - 1)), "divide counter overrun")

endmodule

`default_nettype wire

// File: rtl/core/kronecker_symbol_unit.sv
// kronecker symbol unit: (upper / lower) as -1, 0 or 1 for two signed operands
// request channel: req_valid/req_ready, one transaction carries req_upper_operand
//   and req_lower_operand; only the low WORD_BITS bits of each are used, read as
//   two's complement
// response channel: rsp_valid/rsp_ready, one transaction per request carrying
//   rsp_symbol_value (01 = 1, 00 = 0, 11 = -1)
// sequence: a zero lower operand or two even operands goes straight to the
//   result; otherwise setup, stripping of factors of two from lower, a
//   restoring divide (one quotient bit a cycle), adjust, reduce rounds (one
//   shift or subtract a cycle) until the remainder is seen at zero, and the
//   result, after any wait for the output register
// requests: one at a time; the next request is taken in the cycle after the
//   result is loaded
// the result sits in an output register, so a new request is taken while the
//   previous result still waits; if the receiver stalls the unit holds its next
//   result until that register is free
// reset: synchronous, active high; clears the controller and the response
//   valid, no result is pending afterwards
`default_nettype none

module kronecker_symbol_unit #(
   parameter int WORD_BITS = ks_pkg::WORD_BITS_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     req_valid,
   output logic                                          req_ready,
   input  wire logic signed [ks_pkg::FIELD_BITS-1:0]     req_upper_operand,
   input  wire logic signed [ks_pkg::FIELD_BITS-1:0]     req_lower_operand,
   output logic                                          rsp_valid,
   input  wire logic                                     rsp_ready,
   output logic signed [ks_pkg::SYMBOL_BITS-1:0]         rsp_symbol_value
);
   import ks_pkg::*;

   // command and status between the sequencer and the datapath
   ks_cmd_type  cmd;
   ks_stat_type stat;

   // controller: sequences load, setup, strip, divide, adjust, reduce and emit
   ks_ctrl #(
      .WORD_BITS (WORD_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: operand registers, divider, reduce loop and output register
   ks_dpath #(
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .upper_in   (req_upper_operand[WORD_BITS-1:0]),
      .lower_in   (req_lower_operand[WORD_BITS-1:0]),
      .symbol_out (rsp_symbol_value)
   );

endmodule

`default_nettype wire
